### hw/rtl/lagged_fibonacci_random_generator_core_assert.svh
// assertion macros for the generator core
`ifndef LAGGED_FIBONACCI_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define LAGGED_FIBONACCI_RANDOM_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LFRG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LFRG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lfrg_pkg.sv
`default_nettype none

package lfrg_pkg;

    localparam int WORD_W        = 31;
    localparam int SEED_W        = 32;
    localparam int MUL_W         = 16;
    localparam int PROD_W        = WORD_W + MUL_W;

    localparam int DEF_TABLE_LEN = 607;
    localparam int DEF_SHORT_LAG = 273;
    localparam int WARMUP_STEPS  = 20;

    localparam logic [MUL_W-1:0]  LEHMER_MUL    = 16'd48271;
    localparam logic [WORD_W-1:0] LEHMER_MOD    = 31'h7fffffff;
    localparam logic [WORD_W-1:0] ZERO_SEED_SUB = 31'd89482311;

    typedef enum logic {
        REQ_RESEED = 1'b0,
        REQ_DRAW   = 1'b1
    } req_t;

endpackage

`default_nettype wire

### hw/rtl/lfrg_ram.sv
`default_nettype none

module lfrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 607
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/lagged_fibonacci_random_generator_core.sv
// reseed: busy for TABLE_LEN+20 Lehmer steps, one shared 31x16 multiplier and a
//   fold/subtract reduction give one Lehmer step per SEED_MUL/SEED_RED pair, no result
// draw: DRAW_TAP, DRAW_FEED and DRAW_SUM follow the transfer, then the result strobe;
//   the two table reads and the write-back share the single lag table ram
// a draw before any reseed first runs a reseed with seed 1, adding the reseed time
// reset (async, active low) clears the indices and the seeded flag; the table is unwritten
`default_nettype none

module lagged_fibonacci_random_generator_core #(
    parameter int TABLE_LEN = lfrg_pkg::DEF_TABLE_LEN,
    parameter int SHORT_LAG = lfrg_pkg::DEF_SHORT_LAG
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic signed [lfrg_pkg::SEED_W-1:0] seed,
    output logic                             valid,
    output logic [lfrg_pkg::WORD_W-1:0]      value
);

    `include "lagged_fibonacci_random_generator_core_assert.svh"

    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int TOTAL     = TABLE_LEN + lfrg_pkg::WARMUP_STEPS;
    localparam int CNT_W     = $clog2(TOTAL);
    localparam int FEED_INIT = (TABLE_LEN - (SHORT_LAG % TABLE_LEN)) % TABLE_LEN;
    localparam int WORD_W    = lfrg_pkg::WORD_W;
    localparam int PROD_W    = lfrg_pkg::PROD_W;

    localparam logic [IDX_W:0]   LEN_X    = (IDX_W + 1)'(TABLE_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOTAL - 1);
    localparam logic [CNT_W-1:0] CNT_WARM = CNT_W'(lfrg_pkg::WARMUP_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_RED,
        ST_DRAW_TAP,
        ST_DRAW_FEED,
        ST_DRAW_SUM
    } state_t;

    state_t              state_reg,    state_next;
    logic [IDX_W-1:0]    tap_reg,      tap_next;
    logic [IDX_W-1:0]    feed_reg,     feed_next;
    logic                seeded_reg,   seeded_next;
    logic                pending_reg,  pending_next;
    logic [CNT_W-1:0]    cnt_reg,      cnt_next;
    logic [WORD_W-1:0]   x_reg,        x_next;
    logic [PROD_W-1:0]   prod_reg,     prod_next;
    logic [WORD_W-1:0]   tapw_reg,     tapw_next;
    logic                valid_reg,    valid_next;
    logic [WORD_W-1:0]   value_reg,    value_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [WORD_W-1:0]   seed_red;
    logic [WORD_W-1:0]   lehmer_x;
    logic [WORD_W-1:0]   draw_sum;
    logic [CNT_W-1:0]    warm_addr;

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
        if (idx == '0 || {1'b0, idx} >= LEN_X)
        begin
            return LAST_IDX;
        end
        return idx - 1'b1;
    endfunction

    // seed reduced into 1..2^31-2, signed remainder semantics
    always_comb
    begin
        logic [lfrg_pkg::SEED_W-1:0] raw;
        logic [lfrg_pkg::SEED_W-1:0] mag;
        logic [WORD_W-1:0]           r;
        logic [WORD_W-1:0]           x;
        raw = seed;
        mag = ~raw + 1'b1;
        r   = '0;
        if (raw[lfrg_pkg::SEED_W-1])
        begin
            if (mag[lfrg_pkg::SEED_W-1])
            begin
                r = WORD_W'(1);
            end
            else if (mag[WORD_W-1:0] == lfrg_pkg::LEHMER_MOD)
            begin
                r = '0;
            end
            else
            begin
                r = mag[WORD_W-1:0];
            end
            x = (r == '0) ? '0 : lfrg_pkg::LEHMER_MOD - r;
        end
        else
        begin
            x = (raw[WORD_W-1:0] == lfrg_pkg::LEHMER_MOD) ? '0 : raw[WORD_W-1:0];
        end
        seed_red = (x == '0) ? lfrg_pkg::ZERO_SEED_SUB : x;
    end

    // fold high part onto low part, then one conditional subtract
    always_comb
    begin
        logic [WORD_W:0] s;
        s = {1'b0, prod_reg[WORD_W-1:0]}
            + (WORD_W + 1)'(prod_reg[PROD_W-1:WORD_W]);
        if (s >= {1'b0, lfrg_pkg::LEHMER_MOD})
        begin
            s = s - {1'b0, lfrg_pkg::LEHMER_MOD};
        end
        lehmer_x = s[WORD_W-1:0];
    end

    assign draw_sum  = tapw_reg + ram_rdata;
    assign warm_addr = cnt_reg - CNT_WARM;

    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        feed_next    = feed_reg;
        seeded_next  = seeded_reg;
        pending_next = pending_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        prod_next    = prod_reg;
        tapw_next    = tapw_reg;
        valid_next   = 1'b0;
        value_next   = value_reg;
        ram_we       = 1'b0;
        ram_waddr    = feed_reg;
        ram_wdata    = draw_sum;
        ram_raddr    = feed_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_type == lfrg_pkg::REQ_RESEED || !seeded_reg)
                    begin
                        x_next       = (req_type == lfrg_pkg::REQ_DRAW) ? WORD_W'(1) : seed_red;
                        pending_next = (req_type == lfrg_pkg::REQ_DRAW);
                        tap_next     = '0;
                        feed_next    = IDX_W'(FEED_INIT);
                        cnt_next     = '0;
                        state_next   = ST_SEED_MUL;
                    end
                    else
                    begin
                        state_next = ST_DRAW_TAP;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                prod_next  = PROD_W'(x_reg) * PROD_W'(lfrg_pkg::LEHMER_MUL);
                state_next = ST_SEED_RED;
            end
            ST_SEED_RED:
            begin
                x_next    = lehmer_x;
                ram_we    = (cnt_reg >= CNT_WARM);
                ram_waddr = warm_addr[IDX_W-1:0];
                ram_wdata = lehmer_x;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    seeded_next  = 1'b1;
                    pending_next = 1'b0;
                    state_next   = pending_reg ? ST_DRAW_TAP : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SEED_MUL;
                end
            end
            ST_DRAW_TAP:
            begin
                tap_next   = step_down(tap_reg);
                feed_next  = step_down(feed_reg);
                ram_raddr  = step_down(tap_reg);
                state_next = ST_DRAW_FEED;
            end
            ST_DRAW_FEED:
            begin
                tapw_next  = ram_rdata;
                ram_raddr  = feed_reg;
                state_next = ST_DRAW_SUM;
            end
            ST_DRAW_SUM:
            begin
                ram_we     = 1'b1;
                valid_next = 1'b1;
                value_next = draw_sum;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tap_reg     <= '0;
            feed_reg    <= '0;
            seeded_reg  <= 1'b0;
            pending_reg <= 1'b0;
            cnt_reg     <= '0;
            valid_reg   <= 1'b0;
            value_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            feed_reg    <= feed_next;
            seeded_reg  <= seeded_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
            valid_reg   <= valid_next;
            value_reg   <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        tapw_reg  <= tapw_next;
    end

    lfrg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_LEN)
    ) u_lag_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy  = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign value = value_reg;

    `LFRG_ASSERT_NEXT(a_start_busy, start && !busy, busy, "transfer did not make the core busy")
    `LFRG_ASSERT_NEXT(a_strobe_single, valid, !valid, "result strobe longer than one cycle")
    `LFRG_ASSERT_NOW(a_strobe_idle, valid, !busy && !pending_reg, "result strobe while busy")
    `LFRG_ASSERT_NOW(a_waddr_range, ram_we, {1'b0, ram_waddr} < LEN_X, "table write out of range")

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W       = lfrg_pkg::WORD_W;
    localparam int SEED_W       = lfrg_pkg::SEED_W;
    localparam int WARMUP_STEPS = lfrg_pkg::WARMUP_STEPS;

    localparam logic [lfrg_pkg::MUL_W-1:0] LEHMER_MUL    = lfrg_pkg::LEHMER_MUL;
    localparam logic [WORD_W-1:0]          LEHMER_MOD    = lfrg_pkg::LEHMER_MOD;
    localparam logic [WORD_W-1:0]          ZERO_SEED_SUB = lfrg_pkg::ZERO_SEED_SUB;

    localparam int TBL        = lfrg_pkg::DEF_TABLE_LEN;
    localparam int LAG        = lfrg_pkg::DEF_SHORT_LAG;
    localparam int ITEM_COUNT = 1600;
    localparam int STALL_MAX  = 10000;
    localparam int TAIL_WAIT  = 20;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        lfrg_pkg::req_t    kind;
        logic [SEED_W-1:0] seed_val;
    } stim_t;

    localparam longint unsigned MOD64 = {33'd0, LEHMER_MOD};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic signed [SEED_W-1:0] seed;
    logic                     valid;
    logic [WORD_W-1:0]        value;

    lagged_fibonacci_random_generator_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .seed     (seed),
        .valid    (valid),
        .value    (value)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // generator state mirror
    logic [WORD_W-1:0] lag_mem [0:TBL-1];
    int unsigned       tap_pos;
    int unsigned       feed_pos;
    bit                is_seeded;

    logic [WORD_W-1:0] pending_values [$];
    int                error_count;
    int                stall_cycles;
    bit                steady;
    int                issued;

    function automatic logic [WORD_W-1:0] lehmer_next(logic [WORD_W-1:0] x);
        longint unsigned prod;
        prod = {33'd0, x} * {48'd0, LEHMER_MUL};
        prod = prod % MOD64;
        return prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] reduce_seed(logic [SEED_W-1:0] raw);
        longint unsigned  rem;
        logic [WORD_W-1:0] x;
        if (raw[SEED_W-1])
        begin
            rem = (64'h1_0000_0000 - {32'd0, raw}) % MOD64;
            x = (rem == 0) ? '0 : LEHMER_MOD - rem[WORD_W-1:0];
        end
        else
        begin
            rem = {32'd0, raw} % MOD64;
            x = rem[WORD_W-1:0];
        end
        if (x == '0)
            x = ZERO_SEED_SUB;
        return x;
    endfunction

    function automatic void load_table(logic [SEED_W-1:0] raw);
        logic [WORD_W-1:0] x;
        x = reduce_seed(raw);
        tap_pos  = 0;
        feed_pos = (TBL - (LAG % TBL)) % TBL;
        for (int i = -WARMUP_STEPS; i < TBL; i++)
        begin
            x = lehmer_next(x);
            if (i >= 0)
                lag_mem[i] = x;
        end
        is_seeded = 1'b1;
    endfunction

    function automatic int unsigned ring_down(int unsigned idx);
        return (idx == 0 || idx >= TBL) ? TBL - 1 : idx - 1;
    endfunction

    function automatic logic [WORD_W-1:0] predict_draw();
        logic [WORD_W-1:0] sum;
        if (tap_pos == 0 && !is_seeded)
            load_table(32'd1);
        tap_pos  = ring_down(tap_pos);
        feed_pos = ring_down(feed_pos);
        sum = lag_mem[feed_pos] + lag_mem[tap_pos];
        lag_mem[feed_pos] = sum;
        return sum;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 95)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    task automatic issue(lfrg_pkg::req_t kind, logic [SEED_W-1:0] sd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        seed     <= sd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (kind == lfrg_pkg::REQ_DRAW)
            pending_values.push_back(predict_draw());
        else
            load_table(sd);
        issued++;
    endtask

    function automatic logic [SEED_W-1:0] random_seed();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h8000_0001;
            4: return 32'hffff_fffe;
            5: return 32'h7fff_fffe;
            default: return $urandom;
        endcase
    endfunction

    stim_t directed_rows [23];

    initial
    begin
        int burst;
        rst_n       <= 1'b0;
        start       <= 1'b0;
        req_type    <= lfrg_pkg::REQ_RESEED;
        seed        <= '0;
        error_count = 0;
        issued      = 0;
        steady      = 1'b0;
        tap_pos     = 0;
        feed_pos    = 0;
        is_seeded   = 1'b0;
        foreach (lag_mem[i])
            lag_mem[i] = '0;

        directed_rows = '{
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},   // draw before any seed
            '{lfrg_pkg::REQ_DRAW,   32'hffff_ffff},
            '{lfrg_pkg::REQ_DRAW,   32'h1234_5678},
            '{lfrg_pkg::REQ_RESEED, 32'h0000_0000},   // zero seed
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h7fff_ffff},   // seed equal to the modulus
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h8000_0001},   // negative multiple of the modulus
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h8000_0000},   // most negative seed
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'hffff_ffff},
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h7fff_fffe},
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h0000_0001},
            '{lfrg_pkg::REQ_DRAW,   32'h5555_5555},
            '{lfrg_pkg::REQ_DRAW,   32'haaaa_aaaa},
            '{lfrg_pkg::REQ_RESEED, 32'hffff_fffe},
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h0000_0000},
            '{lfrg_pkg::REQ_RESEED, 32'h0000_0002},   // back to back reseeds
            '{lfrg_pkg::REQ_DRAW,   32'h0000_0000}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].kind, directed_rows[i].seed_val);

        // reseed, then a burst of draws; long bursts wrap both ring indices
        while (issued < ITEM_COUNT + $size(directed_rows))
        begin
            steady = ($urandom_range(3) == 0);
            issue(lfrg_pkg::REQ_RESEED, random_seed());
            if ($urandom_range(3) == 0)
                burst = $urandom_range(800, 610);
            else
                burst = $urandom_range(40, 0);
            if (burst > ITEM_COUNT + $size(directed_rows) - issued)
                burst = ITEM_COUNT + $size(directed_rows) - issued;
            repeat (burst)
                issue(lfrg_pkg::REQ_DRAW, $urandom);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0 || busy)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (error_count == 0 && pending_values.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result checker
    always @(posedge clk)
    begin
        logic [WORD_W-1:0] want;
        if (rst_n && valid)
        begin
            if (pending_values.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result transfer: value %h", value);
            end
            else
            begin
                want = pending_values.pop_front();
                if (value !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("value mismatch: expected %h got %h", want, value);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

`default_nettype wire
